>>> rtl/core/alf_pkg.sv
// Package for the adaptive low-pass filter: widths, register indexes,
// reset values and the sequencer state type. No dependencies.
package alf_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS       = 8;
   localparam int K_BITS          = 8;
   localparam int ACCEL_BITS      = 16;
   localparam int INIT_BITS       = 16;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;
   localparam int K_ONE           = 256;   // unity coefficient
   localparam int ROUND_HALF      = 128;   // half of one LSB after the >>8

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INIT_VALUE = 3'd0,
      CSR_K_INIT     = 3'd1,
      CSR_K_MIN      = 3'd2,
      CSR_K_MAX      = 3'd3,
      CSR_ACCEL_MIN  = 3'd4,
      CSR_ACCEL_MAX  = 3'd5,
      CSR_PREDICTIVE = 3'd6
   } csr_index_type;

   // Register reset values
   localparam logic [INIT_BITS-1:0]  RST_INIT_VALUE = '0;
   localparam logic [K_BITS-1:0]     RST_K_INIT     = 8'd192;
   localparam logic [K_BITS-1:0]     RST_K_MIN      = 8'd64;
   localparam logic [K_BITS-1:0]     RST_K_MAX      = 8'd240;
   localparam logic [ACCEL_BITS-1:0] RST_ACCEL_MIN  = 16'd0;
   localparam logic [ACCEL_BITS-1:0] RST_ACCEL_MAX  = 16'd1000;
   localparam logic                  RST_PREDICTIVE = 1'b0;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHANGE,
      ST_KMUL,
      ST_KDIV_GO,
      ST_KDIV_WAIT,
      ST_KNEW,
      ST_BLEND_A,
      ST_BLEND_B,
      ST_COMMIT
   } state_type;

endpackage

>>> rtl/core/alf_ifs.sv
// Channel interfaces of the adaptive low-pass filter: sample input,
// result output and register write port. Depends on alf_pkg.
interface alf_req_if import alf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface alf_rsp_if import alf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] filtered;
   logic        [K_BITS-1:0]      coefficient;

   modport source (output valid, output filtered, output coefficient, input ready);
   modport sink   (input valid, input filtered, input coefficient, output ready);
endinterface

interface alf_csr_if import alf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/alf_mul.sv
// Shared signed multiplier with registered product.
// Operands are steered by the sequencer in adaptive_lowpass_filter. Depends on alf_pkg.
module alf_mul import alf_pkg::*; #(
   parameter int A_BITS = SAMPLE_BITS_DEF + FRAC_BITS,
   parameter int B_BITS = K_BITS + 2
) (
   input  logic                             clock,
   input  logic signed [A_BITS-1:0]         op_a,
   input  logic signed [B_BITS-1:0]         op_b,
   output logic signed [A_BITS+B_BITS-1:0]  prod_ff
);

   logic signed [A_BITS+B_BITS-1:0] prod_in;

   assign prod_in = (A_BITS+B_BITS)'(op_a) * (A_BITS+B_BITS)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> rtl/core/alf_div.sv
// Restoring divider, one quotient bit per cycle, for the coefficient
// interpolation. Needs num < 2^Q_BITS * den. Depends on alf_pkg.
module alf_div import alf_pkg::*; #(
   parameter int DEN_BITS = ACCEL_BITS,
   parameter int Q_BITS   = K_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DEN_BITS+Q_BITS-1:0]   num,
   input  logic [DEN_BITS-1:0]          den,
   output logic [Q_BITS-1:0]            quot_ff,
   output logic                         done_ff
);

   localparam int NUM_BITS = DEN_BITS + Q_BITS;
   localparam int CNT_BITS = (Q_BITS > 1) ? $clog2(Q_BITS) : 1;

   logic [NUM_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] den_ff, den_in;
   logic [Q_BITS-1:0]   quot_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_in;
   logic                fits;

   always_comb begin
      fits    = (rem_ff >= den_ff);
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = num;
         den_in  = NUM_BITS'(den) << (Q_BITS - 1);
         quot_in = '0;
         cnt_in  = CNT_BITS'(Q_BITS - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - den_ff;
         end
         quot_in = {quot_ff[Q_BITS-2:0], fits};
         den_in  = den_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

endmodule

>>> rtl/core/adaptive_lowpass_filter.sv
// Adaptive low-pass filter (change-driven exponential moving average).
// One sample at a time: a new sample is taken only when the sequencer is idle again.
// With accel_max <= accel_min the divider is skipped.
// The pace is set by the 8-step restoring divider and the one shared multiplier.
// Reset (synchronous, active high) loads register defaults and filter state.
// Depends on alf_pkg, alf_ifs, alf_mul, alf_div.
module adaptive_lowpass_filter import alf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   alf_req_if.sink    req_if,
   alf_rsp_if.source  rsp_if,
   alf_csr_if.sink    csr_if
);

   localparam int SCALED_BITS = SAMPLE_BITS + FRAC_BITS;
   localparam int DIFF_BITS   = SAMPLE_BITS + 1;
   // compare width for |change| against the 16-bit clamps
   localparam int CMP_BITS    = (DIFF_BITS > ACCEL_BITS) ? DIFF_BITS : ACCEL_BITS;
   localparam int MUL_A_BITS  = (SCALED_BITS > ACCEL_BITS) ? SCALED_BITS : ACCEL_BITS + 1;
   localparam int MUL_B_BITS  = K_BITS + 2;
   localparam int MUL_P_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int SUM_BITS    = MUL_P_BITS + FRAC_BITS + 1;
   localparam int KW_BITS     = K_BITS + 2;   // signed room for kmax +/- q
   localparam int NUM_BITS    = ACCEL_BITS + K_BITS;

   // ---------------- configuration registers ----------------
   logic [K_BITS-1:0]            k_init_ff;
   logic [K_BITS-1:0]            k_min_ff;
   logic [K_BITS-1:0]            k_max_ff;
   logic [ACCEL_BITS-1:0]        accel_min_ff;
   logic [ACCEL_BITS-1:0]        accel_max_ff;
   logic                         predictive_ff;

   // ---------------- filter state ----------------
   logic signed [SCALED_BITS-1:0] scaled_ff;
   logic signed [SAMPLE_BITS-1:0] last_ff;
   logic [K_BITS-1:0]             cur_k_ff;

   // ---------------- per-item working registers ----------------
   state_type                     state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [ACCEL_BITS-1:0]         xoff_ff;     // clamped change minus accel_min
   logic [ACCEL_BITS-1:0]         span_ff;     // accel_max - accel_min
   logic                          empty_ff;    // accel_max <= accel_min
   logic                          kdown_ff;    // k_min < k_max: K falls with change
   logic [K_BITS-1:0]             kspan_ff;    // |k_min - k_max|
   logic [K_BITS-1:0]             knew_ff;
   logic [K_BITS-1:0]             kb_ff;       // coefficient used for the blend
   logic signed [MUL_P_BITS-1:0]  term_a_ff;   // scaled_value * kb

   // result register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_ff;
   logic [K_BITS-1:0]             rsp_coef_ff;

   // ---------------- shared units ----------------
   logic signed [MUL_A_BITS-1:0]  mul_a;
   logic signed [MUL_B_BITS-1:0]  mul_b;
   logic signed [MUL_P_BITS-1:0]  prod_ff;
   logic                          div_start;
   logic [K_BITS-1:0]             div_quot;
   logic                          div_done;

   alf_mul #(
      .A_BITS (MUL_A_BITS),
      .B_BITS (MUL_B_BITS)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   alf_div #(
      .DEN_BITS (ACCEL_BITS),
      .Q_BITS   (K_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (prod_ff[NUM_BITS-1:0]),
      .den     (span_ff),
      .quot_ff (div_quot),
      .done_ff (div_done)
   );

   // ---------------- handshakes ----------------
   logic req_take, rsp_take, csr_take, commit;

   assign req_if.ready = (state_ff == ST_IDLE) && !reset;
   assign csr_if.ready = !reset;
   assign req_take     = req_if.valid && req_if.ready;
   assign csr_take     = csr_if.valid && csr_if.ready;
   assign rsp_take     = rsp_if.valid && rsp_if.ready;

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.filtered    = rsp_filtered_ff;
   assign rsp_if.coefficient = rsp_coef_ff;

   // ---------------- change magnitude and clamp (ST_CHANGE) ----------------
   logic signed [DIFF_BITS-1:0] diff;
   logic [CMP_BITS-1:0]         mag_abs, mag_lo, mag_cl;
   logic [CMP_BITS-1:0]         amin_w, amax_w;
   logic [ACCEL_BITS-1:0]       xoff_in;

   always_comb begin
      diff    = DIFF_BITS'(sample_ff) - DIFF_BITS'(last_ff);
      mag_abs = diff[DIFF_BITS-1] ? CMP_BITS'(-diff) : CMP_BITS'(diff);
      amin_w  = CMP_BITS'(accel_min_ff);
      amax_w  = CMP_BITS'(accel_max_ff);
      // low clamp first, then high: crossed clamps end at accel_max
      mag_lo  = (mag_abs < amin_w) ? amin_w : mag_abs;
      mag_cl  = (mag_lo > amax_w) ? amax_w : mag_lo;
      xoff_in = mag_cl[ACCEL_BITS-1:0] - accel_min_ff;
   end

   // ---------------- new coefficient (ST_KNEW) ----------------
   logic signed [KW_BITS-1:0] k_raw, k_lo, k_cl;
   logic signed [KW_BITS-1:0] kmin_w, kmax_w, q_w;
   logic [K_BITS-1:0]         knew_in;

   always_comb begin
      kmin_w = KW_BITS'($signed({1'b0, k_min_ff}));
      kmax_w = KW_BITS'($signed({1'b0, k_max_ff}));
      q_w    = KW_BITS'($signed({1'b0, div_quot}));
      if (empty_ff) begin
         k_raw = kmax_w;
      end else if (kdown_ff) begin
         k_raw = kmax_w - q_w;
      end else begin
         k_raw = kmax_w + q_w;
      end
      // clamp to k_min then k_max, so crossed limits give k_max
      k_lo    = (k_raw < kmin_w) ? kmin_w : k_raw;
      k_cl    = (k_lo > kmax_w) ? kmax_w : k_lo;
      knew_in = k_cl[K_BITS-1:0];
   end

   // ---------------- blend, rounding and saturation (ST_COMMIT) ----------------
   logic signed [SUM_BITS-1:0]    blend_sum, blend_rnd, blend_shr;
   logic signed [SCALED_BITS-1:0] scaled_in;
   logic                          fits_scaled;

   always_comb begin
      blend_sum = SUM_BITS'(term_a_ff) + (SUM_BITS'(prod_ff) <<< FRAC_BITS);
      // symmetric rounding: +half for t >= 0, -half (then floor) for t < 0
      blend_rnd = blend_sum[SUM_BITS-1] ? blend_sum - SUM_BITS'(ROUND_HALF)
                                        : blend_sum + SUM_BITS'(ROUND_HALF);
      blend_shr = blend_rnd >>> FRAC_BITS;
      fits_scaled = (blend_shr[SUM_BITS-1:SCALED_BITS-1] == '0) ||
                    (blend_shr[SUM_BITS-1:SCALED_BITS-1] == '1);
      if (fits_scaled) begin
         scaled_in = blend_shr[SCALED_BITS-1:0];
      end else if (blend_shr[SUM_BITS-1]) begin
         scaled_in = {1'b1, {(SCALED_BITS-1){1'b0}}};
      end else begin
         scaled_in = {1'b0, {(SCALED_BITS-1){1'b1}}};
      end
   end

   // result slot is free or being drained this cycle
   assign commit = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_if.ready);

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CHANGE;
            end
         end
         ST_CHANGE: begin
            state_in = ST_KMUL;
         end
         ST_KMUL: begin
            // |k_min - k_max| * (change - accel_min)
            mul_a    = MUL_A_BITS'($signed({1'b0, xoff_ff}));
            mul_b    = MUL_B_BITS'($signed({1'b0, kspan_ff}));
            state_in = ST_KDIV_GO;
         end
         ST_KDIV_GO: begin
            if (empty_ff) begin
               state_in = ST_KNEW;
            end else begin
               div_start = 1'b1;
               state_in  = ST_KDIV_WAIT;
            end
         end
         ST_KDIV_WAIT: begin
            if (div_done) begin
               state_in = ST_KNEW;
            end
         end
         ST_KNEW: begin
            state_in = ST_BLEND_A;
         end
         ST_BLEND_A: begin
            mul_a    = MUL_A_BITS'(scaled_ff);
            mul_b    = MUL_B_BITS'($signed({1'b0, kb_ff}));
            state_in = ST_BLEND_B;
         end
         ST_BLEND_B: begin
            // sample * (256 - kb); the extra *256 is a shift at the sum
            mul_a    = MUL_A_BITS'(sample_ff);
            mul_b    = MUL_B_BITS'(K_ONE) - MUL_B_BITS'($signed({1'b0, kb_ff}));
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // same operands, so the sample product holds while the result slot is busy
            mul_a = MUL_A_BITS'(sample_ff);
            mul_b = MUL_B_BITS'(K_ONE) - MUL_B_BITS'($signed({1'b0, kb_ff}));
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- working registers ----------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_if.sample;
      end
      if (state_ff == ST_CHANGE) begin
         xoff_ff  <= xoff_in;
         span_ff  <= accel_max_ff - accel_min_ff;
         empty_ff <= (accel_max_ff <= accel_min_ff);
         kdown_ff <= (k_min_ff < k_max_ff);
         kspan_ff <= (k_min_ff < k_max_ff) ? k_max_ff - k_min_ff : k_min_ff - k_max_ff;
      end
      if (state_ff == ST_KNEW) begin
         knew_ff <= knew_in;
         kb_ff   <= predictive_ff ? knew_in : cur_k_ff;
      end
      if (state_ff == ST_BLEND_B) begin
         term_a_ff <= prod_ff;
      end
   end

   // ---------------- config, filter state and result ----------------
   logic signed [SAMPLE_BITS-1:0] csr_init_wrap;

   // init_value is sign-extended or wrapped to the sample width
   assign csr_init_wrap = SAMPLE_BITS'($signed(csr_if.data[INIT_BITS-1:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         k_init_ff     <= RST_K_INIT;
         k_min_ff      <= RST_K_MIN;
         k_max_ff      <= RST_K_MAX;
         accel_min_ff  <= RST_ACCEL_MIN;
         accel_max_ff  <= RST_ACCEL_MAX;
         predictive_ff <= RST_PREDICTIVE;
         last_ff       <= SAMPLE_BITS'($signed(RST_INIT_VALUE));
         scaled_ff     <= SCALED_BITS'($signed(RST_INIT_VALUE)) <<< FRAC_BITS;
         cur_k_ff      <= RST_K_INIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (commit) begin
            scaled_ff    <= scaled_in;
            last_ff      <= scaled_in[SCALED_BITS-1:FRAC_BITS];
            cur_k_ff     <= knew_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_take) begin
            case (csr_index_type'(csr_if.index))
               CSR_INIT_VALUE: begin
                  // reload the filter from the new start value
                  last_ff   <= csr_init_wrap;
                  scaled_ff <= SCALED_BITS'(csr_init_wrap) <<< FRAC_BITS;
                  cur_k_ff  <= k_init_ff;
               end
               CSR_K_INIT:     k_init_ff     <= csr_if.data[K_BITS-1:0];
               CSR_K_MIN:      k_min_ff      <= csr_if.data[K_BITS-1:0];
               CSR_K_MAX:      k_max_ff      <= csr_if.data[K_BITS-1:0];
               CSR_ACCEL_MIN:  accel_min_ff  <= csr_if.data[ACCEL_BITS-1:0];
               CSR_ACCEL_MAX:  accel_max_ff  <= csr_if.data[ACCEL_BITS-1:0];
               CSR_PREDICTIVE: predictive_ff <= csr_if.data[0];
               default: begin
                  // unmapped index: write dropped
               end
            endcase
         end
      end
      if (commit) begin
         rsp_filtered_ff <= scaled_in[SCALED_BITS-1:FRAC_BITS];
         rsp_coef_ff     <= knew_ff;
      end
   end

endmodule

>>> sim/tb_adaptive_lowpass_filter.sv
// Self-checking testbench for adaptive_lowpass_filter: drives samples and register
// writes, predicts every result in a scoreboard class and compares field by field.
// Depends on alf_pkg, alf_ifs and the filter RTL.
module tb_adaptive_lowpass_filter import alf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW          = SAMPLE_BITS_DEF;
   localparam int SCALED_BITS = SW + FRAC_BITS;
   localparam int CSR_COUNT   = int'(CSR_PREDICTIVE) + 1;
   // index with no register behind it; the block must ignore the write
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 3'd7;

   localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

   localparam int     RANDOM_PHASES    = 14;
   localparam int     PHASE_ITEMS      = 125;
   localparam int     LONG_HOLD_CYCLES = 500;
   localparam int     DRAIN_CYCLES     = 40;    // idle time after the final drain
   localparam longint TIMEOUT_NS       = 4_000_000;

   typedef struct {
      logic signed [SW-1:0]   filtered;
      logic        [K_BITS-1:0] coefficient;
   } filter_out_type;

   // Scoreboard: own copy of the registers and filter state, predicts the
   // output for each accepted sample and checks results in order.
   class ema_scoreboard;
      logic signed [INIT_BITS-1:0]  init_value;
      logic        [K_BITS-1:0]     k_init, k_min, k_max;
      logic        [ACCEL_BITS-1:0] accel_min, accel_max;
      logic                         predictive;
      longint                       scaled_value, last_output, current_k;
      filter_out_type               pending_outputs[$];
      int                           errors, checked;

      function new();
         init_value = RST_INIT_VALUE;
         k_init     = RST_K_INIT;
         k_min      = RST_K_MIN;
         k_max      = RST_K_MAX;
         accel_min  = RST_ACCEL_MIN;
         accel_max  = RST_ACCEL_MAX;
         predictive = RST_PREDICTIVE;
         errors     = 0;
         checked    = 0;
         reload();
      endfunction

      // filter state restarts from init_value and the present k_init
      function void reload();
         last_output  = longint'(init_value);
         scaled_value = last_output * K_ONE;
         current_k    = longint'(k_init);
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index,
                              logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_INIT_VALUE: begin
               init_value = data[INIT_BITS-1:0];
               reload();
            end
            CSR_K_INIT:     k_init     = data[K_BITS-1:0];
            CSR_K_MIN:      k_min      = data[K_BITS-1:0];
            CSR_K_MAX:      k_max      = data[K_BITS-1:0];
            CSR_ACCEL_MIN:  accel_min  = data[ACCEL_BITS-1:0];
            CSR_ACCEL_MAX:  accel_max  = data[ACCEL_BITS-1:0];
            CSR_PREDICTIVE: predictive = data[0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [SW-1:0] sample);
         longint         s, change, amin, amax, kmin, kmax, knew, kb, t, nv;
         longint         lim_hi, lim_lo;
         filter_out_type out;
         lim_hi = (longint'(1) << (SCALED_BITS - 1)) - 1;
         lim_lo = -(longint'(1) << (SCALED_BITS - 1));
         s      = longint'(sample);
         amin   = longint'(accel_min);
         amax   = longint'(accel_max);
         kmin   = longint'(k_min);
         kmax   = longint'(k_max);

         // change magnitude, clamped low first, then high
         change = s - last_output;
         if (change < 0) change = -change;
         if (change < amin) change = amin;
         if (change > amax) change = amax;

         // empty range pins K at k_max; division truncates toward zero
         if (amax <= amin)
            knew = kmax;
         else
            knew = kmax + ((kmin - kmax) * (change - amin)) / (amax - amin);
         if (knew < kmin) knew = kmin;
         if (knew > kmax) knew = kmax;

         kb = predictive ? knew : current_k;
         t  = scaled_value * kb + (s * K_ONE) * (K_ONE - kb);
         // symmetric rounding: arithmetic shift floors the negative side
         if (t >= 0)
            nv = (t + ROUND_HALF) >>> FRAC_BITS;
         else
            nv = (t - ROUND_HALF) >>> FRAC_BITS;
         if (nv > lim_hi) nv = lim_hi;
         if (nv < lim_lo) nv = lim_lo;

         scaled_value    = nv;
         last_output     = nv >>> FRAC_BITS;
         current_k       = knew;
         out.filtered    = last_output[SW-1:0];
         out.coefficient = knew[K_BITS-1:0];
         pending_outputs.push_back(out);
      endfunction

      function void check_result(logic signed [SW-1:0] filtered,
                                 logic [K_BITS-1:0] coefficient);
         filter_out_type want;
         if (pending_outputs.size() == 0) begin
            $error("result with no sample waiting: filtered %0d coefficient %0d",
                   filtered, coefficient);
            errors++;
            return;
         end
         want = pending_outputs.pop_front();
         checked++;
         if (filtered !== want.filtered) begin
            $error("filtered: expected %0d, actual %0d", want.filtered, filtered);
            errors++;
         end
         if (coefficient !== want.coefficient) begin
            $error("coefficient: expected %0d, actual %0d", want.coefficient, coefficient);
            errors++;
         end
      endfunction

      function int pending();
         return pending_outputs.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   alf_req_if #(.SAMPLE_BITS(SW)) req_ch ();
   alf_rsp_if #(.SAMPLE_BITS(SW)) rsp_ch ();
   alf_csr_if                     csr_ch ();

   adaptive_lowpass_filter #(.SAMPLE_BITS(SW)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   ema_scoreboard        sb;
   bit                   idling        = 1'b1;  // random gaps on both sides
   bit                   long_hold_req = 1'b0;  // asks the receiver for a long stall
   int                   sent          = 0;
   int                   csr_writes    = 0;
   logic signed [SW-1:0] prev_sample   = '0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends here.
   initial begin
      #TIMEOUT_NS;
      $display("adaptive_lowpass_filter: mismatch");
      $finish;
   end

   // Receiver: random stall bursts, plus one long stall on request, counted
   // here so the sender keeps pushing meanwhile.
   initial begin
      int unsigned hold;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            hold          = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
         end
         if (hold != 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            hold = $urandom_range(0, 8);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Result monitor: every accepted item goes to the scoreboard.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_result(rsp_ch.filtered, rsp_ch.coefficient);
   end

   // Offer one sample, optionally after an idle burst; returns at the
   // accepting edge with valid still high.
   task automatic send_sample(input logic signed [SW-1:0] sample);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= sample;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_sample(sample);
      sent++;
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (2) @(posedge clock);
   endtask

   // Register write; only called with the block drained.
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0]  data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      sb.write_reg(index, data);
      csr_writes++;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Register value: extremes, small ranges, or full random data
   // (upper bits random too, the narrow registers must drop them).
   function automatic logic [CSR_DATA_BITS-1:0] pick_value();
      logic [CSR_DATA_BITS-1:0] v;
      v = CSR_DATA_BITS'($urandom);
      case ($urandom_range(0, 7))
         0:       v = '0;
         1:       v = '1;
         2:       v = CSR_DATA_BITS'($urandom_range(0, 2000));
         default: ;
      endcase
      return v;
   endfunction

   // All registers, starting at a random index so init_value (which
   // reloads state from k_init) lands at a different point each time.
   task automatic random_settings();
      int first;
      first = $urandom_range(0, CSR_COUNT - 1);
      for (int j = 0; j < CSR_COUNT; j++)
         csr_write(CSR_INDEX_BITS'((first + j) % CSR_COUNT), pick_value());
      if ($urandom_range(0, 3) == 0)
         csr_write(CSR_UNMAPPED, CSR_DATA_BITS'($urandom));
   endtask

   // Mix of full-range samples, small walks that keep the change inside the
   // interpolation range, rail values and repeats.
   function automatic logic signed [SW-1:0] next_sample(input logic signed [SW-1:0] prev);
      int span;
      int delta;
      span  = (sb.accel_max > 2000) ? 2000 : int'(sb.accel_max) + 1;
      delta = int'($urandom_range(0, 2 * span)) - span;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return SW'($urandom);
         4, 5, 6, 7: return SW'(int'(prev) + delta);
         8:          return $urandom_range(0, 1) ? SMAX : SMIN;
         default:    return prev;
      endcase
   endfunction

   initial begin
      sb = new();
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.sample <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.index  <= CSR_INIT_VALUE;
      csr_ch.data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: rails, then small values around zero
      send_sample(SMAX);
      send_sample(SMIN);
      send_sample('0);
      send_sample(SW'(-1));
      send_sample(SW'(1));
      send_sample('0);
      wait_drained();

      // predictive mode: new K applies to the current sample
      csr_write(CSR_PREDICTIVE, 16'd1);
      send_sample(SMIN);
      send_sample(SMAX);
      send_sample(SW'(100));
      send_sample(SW'(5));
      wait_drained();

      // empty change range, K pinned at k_max
      csr_write(CSR_ACCEL_MIN, 16'd300);
      csr_write(CSR_ACCEL_MAX, 16'd300);
      send_sample(SW'(1000));
      send_sample(SW'(-20));
      wait_drained();

      // crossed clamps on both the change and K
      csr_write(CSR_ACCEL_MIN, 16'd2000);
      csr_write(CSR_ACCEL_MAX, 16'd100);
      csr_write(CSR_K_MIN, 16'd200);
      csr_write(CSR_K_MAX, 16'd50);
      csr_write(CSR_PREDICTIVE, 16'd0);
      send_sample(SW'(30000));
      send_sample(SW'(10));
      wait_drained();

      // widest ranges; reload at the negative rail with K at its top,
      // plus a write to an unmapped index that must change nothing
      csr_write(CSR_K_MIN, 16'd0);
      csr_write(CSR_K_MAX, 16'd255);
      csr_write(CSR_ACCEL_MIN, 16'd0);
      csr_write(CSR_ACCEL_MAX, 16'hFFFF);
      csr_write(CSR_K_INIT, 16'd255);
      csr_write(CSR_INIT_VALUE, 16'h8000);
      csr_write(CSR_UNMAPPED, 16'h1234);
      send_sample(SMAX);
      send_sample(SMIN);
      send_sample(SMAX);
      wait_drained();

      // reload at the positive rail with K zero: output follows the input
      csr_write(CSR_K_INIT, 16'd0);
      csr_write(CSR_INIT_VALUE, 16'h7FFF);
      send_sample(SMIN);
      send_sample('0);

      // random phases, each under fresh register settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         random_settings();
         if (p == RANDOM_PHASES - 1)
            idling = 1'b0;              // final stretch at full rate
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == 20)
               long_hold_req = 1'b1;    // back up the block, input must stall
            if (p == 5 && i == 60)
               wait_drained();          // sender pause mid-phase
            prev_sample = next_sample(prev_sample);
            send_sample(prev_sample);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d samples and %0d checked results under %0d register writes,",
               sent, sb.checked, csr_writes);
      $display("with rails, crossed and empty ranges, reloads and both K modes");
      if (sb.errors == 0)
         $display("adaptive_lowpass_filter: match");
      else
         $display("adaptive_lowpass_filter: mismatch");
      $finish;
   end

endmodule
